// ===== rtl/cdgf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdgf_pkg;

  localparam int THRESH_BITS = 10;
  localparam int RUN_BITS    = 2;
  localparam int WARM_BITS   = 4;
  localparam int BAND_BITS   = 10;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [RUN_BITS-1:0]  RUN_MAX  = 2'd3;
  localparam logic [WARM_BITS-1:0] WARM_MAX = 4'd15;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd50;
  localparam logic [RUN_BITS-1:0]    RUN_RESET    = 2'd3;
  localparam logic [WARM_BITS-1:0]   WARM_RESET   = 4'd10;
  localparam logic [BAND_BITS-1:0]   BAND_RESET   = 10'd10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_JUMP_THRESHOLD = 3'd0,
    REG_STABLE_RUN     = 3'd1,
    REG_WARMUP_LIMIT   = 3'd2,
    REG_WARMUP_BAND    = 3'd3,
    REG_EXTERNAL_MODE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] jump_threshold;
    logic [RUN_BITS-1:0]    stable_run;
    logic [WARM_BITS-1:0]   warmup_limit;
    logic [BAND_BITS-1:0]   warmup_band;
    logic                   external_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/cdgf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdgf_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [cdgf_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [cdgf_pkg::CFG_DATA_BITS-1:0] wr_data,
  output cdgf_pkg::cfg_t                    cfg
);

  cdgf_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (wr_index)
        cdgf_pkg::REG_JUMP_THRESHOLD:
          cfg_next.jump_threshold = wr_data[cdgf_pkg::THRESH_BITS-1:0];
        cdgf_pkg::REG_STABLE_RUN:
          cfg_next.stable_run = wr_data[cdgf_pkg::RUN_BITS-1:0];
        cdgf_pkg::REG_WARMUP_LIMIT:
          cfg_next.warmup_limit = wr_data[cdgf_pkg::WARM_BITS-1:0];
        cdgf_pkg::REG_WARMUP_BAND:
          cfg_next.warmup_band = wr_data[cdgf_pkg::BAND_BITS-1:0];
        cdgf_pkg::REG_EXTERNAL_MODE:
          cfg_next.external_mode = wr_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_threshold <= cdgf_pkg::THRESH_RESET;
      cfg.stable_run     <= cdgf_pkg::RUN_RESET;
      cfg.warmup_limit   <= cdgf_pkg::WARM_RESET;
      cfg.warmup_band    <= cdgf_pkg::BAND_RESET;
      cfg.external_mode  <= 1'b1;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdgf_div5.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdgf_div5 #(
  parameter int SW = 13
) (
  input  logic [SW-1:0] num,
  output logic [SW-1:0] quo
);

  localparam int K = SW + 1;
  localparam logic [K-1:0] RECIP = K'((2 ** K) / 5);
  localparam logic [SW-1:0] DIVISOR = SW'(5);

  logic [SW+K-1:0] prod;
  logic [SW-1:0]   q0;
  logic [SW+2:0]   q5;
  logic [SW-1:0]   rem;

  // reciprocal estimate is low by at most one
  always_comb begin
    prod = {{K{1'b0}}, num} * {{SW{1'b0}}, RECIP};
    q0   = prod[SW+K-1:K];
    q5   = {3'b000, q0} + {1'b0, q0, 2'b00};
    rem  = num - q5[SW-1:0];
    quo  = (rem >= DIVISOR) ? q0 + SW'(1) : q0;
  end

endmodule

`default_nettype wire

// ===== rtl/cdgf_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdgf_filter #(
  parameter int DUTY_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [DUTY_BITS-1:0] raw,
  input  cdgf_pkg::cfg_t       cfg,
  output logic [DUTY_BITS-1:0] filt_next,
  output logic                 settled_next
);

  localparam int SW = DUTY_BITS + 3;
  localparam int CW = (DUTY_BITS > cdgf_pkg::THRESH_BITS) ? DUTY_BITS : cdgf_pkg::THRESH_BITS;

  logic [DUTY_BITS-1:0]          filtered_value;
  logic [DUTY_BITS-1:0]          prior_filtered;
  logic [DUTY_BITS-1:0]          last_sample;
  logic [cdgf_pkg::RUN_BITS-1:0]  equal_run;
  logic                          settled;
  logic [cdgf_pkg::WARM_BITS-1:0] warmup_count;

  logic [DUTY_BITS-1:0]          prior_next;
  logic [cdgf_pkg::RUN_BITS-1:0]  run_next;
  logic [cdgf_pkg::WARM_BITS-1:0] warm_next;

  logic [DUTY_BITS-1:0] d_raw;
  logic [DUTY_BITS-1:0] d_prev;
  logic [cdgf_pkg::RUN_BITS-1:0] run_inc;
  logic                 jump;
  logic [SW-1:0]        blend_sum;
  logic [SW-1:0]        blend_quo;
  logic [DUTY_BITS-1:0] track_x;
  logic [DUTY_BITS:0]   track_sum;

  cdgf_div5 #(.SW(SW)) u_div5 (
    .num (blend_sum),
    .quo (blend_quo)
  );

  always_comb begin
    d_raw  = (raw > filtered_value) ? raw - filtered_value : filtered_value - raw;
    d_prev = (prior_filtered > filtered_value) ? prior_filtered - filtered_value
                                               : filtered_value - prior_filtered;
    jump = CW'(d_raw) >= CW'(cfg.jump_threshold);

    if (raw == last_sample) begin
      run_inc = (equal_run < cdgf_pkg::RUN_MAX) ? equal_run + 2'd1 : equal_run;
    end else begin
      run_inc = '0;
    end

    blend_sum = {2'b00, filtered_value, 1'b0} + {2'b00, raw, 1'b0} + {3'b000, raw};
    track_x   = (d_raw > d_prev) ? prior_filtered : raw;
    track_sum = {1'b0, filtered_value} + {1'b0, track_x};

    filt_next    = filtered_value;
    settled_next = settled;
    prior_next   = prior_filtered;
    run_next     = equal_run;
    warm_next    = warmup_count;

    if (cfg.external_mode) begin
      if (jump) begin
        filt_next    = raw;
        settled_next = 1'b0;
      end else if (!settled) begin
        run_next = run_inc;
        if (run_inc >= cfg.stable_run) begin
          filt_next    = raw;
          settled_next = 1'b1;
        end else if (warmup_count <= cfg.warmup_limit) begin
          if (CW'(d_raw) < CW'(cfg.warmup_band)) begin
            filt_next = blend_quo[DUTY_BITS-1:0];
          end
          if (warmup_count < cdgf_pkg::WARM_MAX) begin
            warm_next = warmup_count + 4'd1;
          end
        end else begin
          filt_next  = track_sum[DUTY_BITS:1];
          prior_next = track_sum[DUTY_BITS:1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_value <= '0;
      prior_filtered <= '0;
      last_sample    <= '0;
      equal_run      <= '0;
      settled        <= 1'b0;
      warmup_count   <= '0;
    end else if (fire && cfg.external_mode) begin
      filtered_value <= filt_next;
      prior_filtered <= prior_next;
      last_sample    <= raw;
      equal_run      <= run_next;
      settled        <= settled_next;
      warmup_count   <= warm_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/captured_duty_glitch_filter.sv =====
// captured duty glitch filter, one channel
// input channel: raw_duty with in_valid / in_stall; a request is taken at a
//   rising edge with in_valid high and in_stall low
// output channel: filtered_duty and settled_flag with out_valid / out_stall;
//   every input request gives exactly one output request, in order
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data, always
//   ready; indexes 0..4 are jump threshold, stable run, warm-up limit,
//   warm-up band and external mode, other indexes are dropped
// input to output: the input register loads at the accept edge, then one pass
//   of compare and blend logic goes into the result register, which sets
//   out_valid; a receiver stall can hold the request in the input register
// throughput: one request per cycle while out_stall is low; filter state is
//   updated in the same pass as the result register; the next request sees it
// receiver stall: the result register holds, the input register still
//   takes one more request, then in_stall rises until the result is taken
// reset: synchronous, clears both valid flags and the filter state, loads
//   default config (threshold 50, run 3, limit 10, band 10, external on)
`timescale 1ns / 1ps
`default_nettype none

module captured_duty_glitch_filter #(
  parameter int DUTY_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [DUTY_BITS-1:0]              raw_duty,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [DUTY_BITS-1:0]              filtered_duty,
  output logic                              settled_flag,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdgf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cdgf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  cdgf_pkg::cfg_t cfg;

  logic                 in_full;
  logic [DUTY_BITS-1:0] in_raw;
  logic                 advance;
  logic                 in_take;
  logic [DUTY_BITS-1:0] filt_next;
  logic                 settled_next;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_take   = in_valid && !in_stall;

  cdgf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cdgf_filter #(.DUTY_BITS(DUTY_BITS)) u_filter (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .raw          (in_raw),
    .cfg          (cfg),
    .filt_next    (filt_next),
    .settled_next (settled_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_raw <= raw_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_duty <= filt_next;
      settled_flag  <= settled_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled while the result register is free");

  a_advance_loads_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced request did not reach the result register");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !in_full) |=> !out_valid)
    else $error("result repeated after it was taken");
`endif

endmodule

`default_nettype wire

// ===== test/captured_duty_glitch_filter_test.sv =====
`timescale 1ns / 1ps

module captured_duty_glitch_filter_test;

  localparam int DW = 10;
  localparam int DUTY_MAX = (1 << DW) - 1;
  localparam int HOLD_CYCLES = 200;
  localparam logic [cdgf_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic [DW-1:0] duty;
    logic          settled;
  } duty_result_t;

  class duty_board;
    cdgf_pkg::cfg_t                 cfg;
    logic [DW-1:0]                  value;
    logic [DW-1:0]                  prior;
    logic [DW-1:0]                  last;
    logic [cdgf_pkg::RUN_BITS-1:0]  run;
    logic                           settled;
    logic [cdgf_pkg::WARM_BITS-1:0] warm;
    duty_result_t                   awaited_duty[$];
    int                             error_count;

    function new();
      cfg.jump_threshold = cdgf_pkg::THRESH_RESET;
      cfg.stable_run = cdgf_pkg::RUN_RESET;
      cfg.warmup_limit = cdgf_pkg::WARM_RESET;
      cfg.warmup_band = cdgf_pkg::BAND_RESET;
      cfg.external_mode = 1'b1;
      value = '0;
      prior = '0;
      last = '0;
      run = '0;
      settled = 1'b0;
      warm = '0;
      error_count = 0;
    endfunction

    function logic [DW-1:0] abs_delta(logic [DW-1:0] a, logic [DW-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void write_reg(logic [cdgf_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [cdgf_pkg::CFG_DATA_BITS-1:0] data);
      unique case (idx)
        cdgf_pkg::REG_JUMP_THRESHOLD:
          cfg.jump_threshold = data[cdgf_pkg::THRESH_BITS-1:0];
        cdgf_pkg::REG_STABLE_RUN:     cfg.stable_run = data[cdgf_pkg::RUN_BITS-1:0];
        cdgf_pkg::REG_WARMUP_LIMIT:   cfg.warmup_limit = data[cdgf_pkg::WARM_BITS-1:0];
        cdgf_pkg::REG_WARMUP_BAND:    cfg.warmup_band = data[cdgf_pkg::BAND_BITS-1:0];
        cdgf_pkg::REG_EXTERNAL_MODE:  cfg.external_mode = data[0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [DW-1:0] raw);
      logic [DW-1:0] c;
      logic [DW-1:0] d_raw;
      logic [DW-1:0] d_prev;
      logic [DW-1:0] x;
      logic [DW+2:0] mix;
      logic [DW:0]   sum;
      duty_result_t  res;
      if (cfg.external_mode) begin
        c = value;
        d_raw = abs_delta(raw, c);
        if (d_raw >= cfg.jump_threshold) begin
          value = raw;
          settled = 1'b0;
        end else if (!settled) begin
          if (raw == last) begin
            if (run != cdgf_pkg::RUN_MAX) run = run + 1'b1;
          end else begin
            run = '0;
          end
          if (run >= cfg.stable_run) begin
            value = raw;
            settled = 1'b1;
          end else begin
            d_prev = abs_delta(c, prior);
            if (warm <= cfg.warmup_limit) begin
              if (d_raw < cfg.warmup_band) begin
                mix = (DW+3)'((2 * {3'b000, c} + 3 * {3'b000, raw}) / 5);
                value = mix[DW-1:0];
              end
              if (warm != cdgf_pkg::WARM_MAX) warm = warm + 1'b1;
            end else begin
              x = (d_raw > d_prev) ? prior : raw;
              sum = {1'b0, c} + {1'b0, x};
              value = sum[DW:1];
              prior = value;
            end
          end
        end
        last = raw;
      end
      res.duty = value;
      res.settled = settled;
      awaited_duty.push_back(res);
    endfunction

    function void check_duty(logic [DW-1:0] duty, logic flag);
      duty_result_t want;
      if (awaited_duty.size() == 0) begin
        $error("result with no pending request: filtered_duty %0d settled_flag %0d",
               duty, flag);
        error_count++;
        return;
      end
      want = awaited_duty.pop_front();
      if (duty !== want.duty) begin
        $error("filtered_duty expected %0d actual %0d", want.duty, duty);
        error_count++;
      end
      if (flag !== want.settled) begin
        $error("settled_flag expected %0d actual %0d", want.settled, flag);
        error_count++;
      end
    endfunction

    function int pending();
      return awaited_duty.size();
    endfunction

    function void check_drained();
      if (awaited_duty.size() != 0) begin
        $error("%0d results never arrived", awaited_duty.size());
        error_count++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [DW-1:0]                      raw_duty = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [DW-1:0]                      filtered_duty;
  logic                               settled_flag;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [cdgf_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [cdgf_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  duty_board     board;
  int            hold_asks = 0;
  logic [DW-1:0] last_raw = '0;

  captured_duty_glitch_filter #(.DUTY_BITS(DW)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .raw_duty(raw_duty),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_duty(filtered_duty),
    .settled_flag(settled_flag),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_sample(raw_duty);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_duty(filtered_duty, settled_flag);
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver
    int seg_left;
    int seg_kind;
    int holds_done;
    seg_left = 0;
    seg_kind = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 3);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        unique case (seg_kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("captured_duty_glitch_filter_test: errors");
    $finish;
  end

  function automatic logic [DW-1:0] pick_sample(logic [DW-1:0] prev);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 40) v = int'(prev);
    else if (pick < 75) v = int'(prev) + int'($urandom_range(0, 24)) - 12;
    else if (pick < 87) v = int'(prev) + int'($urandom_range(0, 240)) - 120;
    else if (pick < 90) v = pick[0] ? 0 : DUTY_MAX;
    else v = $urandom_range(0, DUTY_MAX);
    if (v < 0) v = 0;
    if (v > DUTY_MAX) v = DUTY_MAX;
    return v[DW-1:0];
  endfunction

  task automatic send_sample(logic [DW-1:0] raw);
    in_valid <= 1'b1;
    raw_duty <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [cdgf_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [cdgf_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic write_all(int thr, int run, int lim, int band, int ext);
    write_reg(cdgf_pkg::REG_JUMP_THRESHOLD, thr[cdgf_pkg::CFG_DATA_BITS-1:0]);
    write_reg(cdgf_pkg::REG_STABLE_RUN, run[cdgf_pkg::CFG_DATA_BITS-1:0]);
    write_reg(cdgf_pkg::REG_WARMUP_LIMIT, lim[cdgf_pkg::CFG_DATA_BITS-1:0]);
    write_reg(cdgf_pkg::REG_WARMUP_BAND, band[cdgf_pkg::CFG_DATA_BITS-1:0]);
    write_reg(cdgf_pkg::REG_EXTERNAL_MODE, ext[cdgf_pkg::CFG_DATA_BITS-1:0]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_samples(int count, int hold_at);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 30);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_asks++;
      last_raw = pick_sample(last_raw);
      send_sample(last_raw);
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
    end
  endtask

  initial begin : stimulus
    int directed[23] = '{0, 1023, 1023, 1023, 1023, 1020, 1023, 0, 4, 7, 2, 9, 30,
                         5, 5, 6, 600, 601, 603, 602, 604, 606, 605};
    int drain;
    int junk;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // jump, settling, settled repeats, warm-up blend and out-of-band steps
    foreach (directed[k]) send_sample(directed[k][DW-1:0]);
    last_raw = directed[22][DW-1:0];
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          write_all(DUTY_MAX, 1, 0, DUTY_MAX, 1);
          junk = $urandom_range(0, DUTY_MAX);
          write_reg(REG_UNMAPPED, junk[cdgf_pkg::CFG_DATA_BITS-1:0]);
        end
        1: write_all(1, 3, 14, 0, 1);
        2: write_all(0, 0, 15, 1, 1);
        3: write_reg(cdgf_pkg::REG_EXTERNAL_MODE, 10'h3fe);
        4: write_all(100, 2, 5, 10, 1);
        default: write_all($urandom_range(1, 400), $urandom_range(0, DUTY_MAX),
                           $urandom_range(0, DUTY_MAX), $urandom_range(0, 80), 1);
      endcase
      run_samples((phase == 3) ? 20 : 75, (phase == 1 || phase == 6) ? 10 : -1);
      wait_idle();
    end

    in_valid <= 1'b0;
    drain = 0;
    while (board.pending() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    board.check_drained();
    if (board.error_count == 0) begin
      $display("captured_duty_glitch_filter_test: clean");
    end else begin
      $display("captured_duty_glitch_filter_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cdgf_pkg.sv
rtl/cdgf_cfg.sv
rtl/cdgf_div5.sv
rtl/cdgf_filter.sv
rtl/captured_duty_glitch_filter.sv
test/captured_duty_glitch_filter_test.sv
